@@ hdl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; compiled first.
`default_nettype none

package spq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_DATA_BITS     = 32;

    // Operation codes on the request channel.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      occupied;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/spq_if.sv @@
// Valid/ready channel interfaces for request and response transfers.
// Depends on spq_pkg for default widths.
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS
);
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [DATA_BITS-1:0]     data_handle;

    modport source (output valid, output op, output priority_req, output data_handle,
                    input ready);
    modport sink   (input valid, input op, input priority_req, input data_handle,
                    output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS
);
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [PRIORITY_BITS-1:0] removed_priority;
    logic [DATA_BITS-1:0]     removed_data;
    logic                     head_valid;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [DATA_BITS-1:0]     head_data;
    logic [COUNT_BITS-1:0]    entry_count;

    modport source (output valid, output status, output removed_priority,
                    output removed_data, output head_valid, output head_priority,
                    output head_data, output entry_count, input ready);
    modport sink   (input valid, input status, input removed_priority,
                    input removed_data, input head_valid, input head_priority,
                    input head_data, input entry_count, output ready);
endinterface

`default_nettype wire

@@ hdl/spq_cell.sv @@
// One slot of the sorted shift chain: holds an entry, compares it with the
// incoming priority and takes its own, the new, or a neighbor's entry. Uses spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS
)
(
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic [PRIORITY_BITS-1:0] new_pri,
    input  wire logic [DATA_BITS-1:0]     new_data,
    input  wire logic                     left_keep,
    input  wire logic [PRIORITY_BITS-1:0] left_pri,
    input  wire logic [DATA_BITS-1:0]     left_data,
    input  wire logic [PRIORITY_BITS-1:0] right_pri,
    input  wire logic [DATA_BITS-1:0]     right_data,
    output logic                          keep,
    output logic [PRIORITY_BITS-1:0]      pri,
    output logic [DATA_BITS-1:0]          data,
    output logic [PRIORITY_BITS-1:0]      pri_next,
    output logic [DATA_BITS-1:0]          data_next
);

    logic [PRIORITY_BITS-1:0] pri_reg;
    logic [DATA_BITS-1:0]     data_reg;

    // Ties stay ahead of the new entry: FIFO among equal priorities.
    assign keep = ctrl.occupied && (pri_reg >= new_pri);

    always_comb
    begin
        pri_next  = pri_reg;
        data_next = data_reg;
        unique case (ctrl.cmd)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (keep)
                begin
                end
                else if (left_keep)
                begin
                    pri_next  = new_pri;
                    data_next = new_data;
                end
                else
                begin
                    pri_next  = left_pri;
                    data_next = left_data;
                end
            end
            CELL_SHIFT:
            begin
                pri_next  = right_pri;
                data_next = right_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pri_reg  <= pri_next;
        data_reg <= data_next;
    end

    assign pri  = pri_reg;
    assign data = data_reg;

endmodule

`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue: a chain of QUEUE_DEPTH cells kept in descending order.
// The response shows in the cycle after the request transfer; one item per
// cycle while responses are taken; compare-and-shift acts on all cells at once.
// Reset (rst_n low, asynchronous) empties the queue and the response register;
// slot contents are not cleared and are never read before being written.
// Depends on spq_pkg, spq_if and spq_cell.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS
)
(
    input wire logic clk,
    input wire logic rst_n,
    spq_req_if.sink  req,
    spq_rsp_if.source rsp
);

    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

    // Fill count; cell i is occupied when i < count_reg.
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    // Response register.
    logic                     out_valid_reg;
    status_t                  status_reg;
    logic [PRIORITY_BITS-1:0] rem_pri_reg;
    logic [DATA_BITS-1:0]     rem_data_reg;
    logic                     head_valid_reg;
    logic [PRIORITY_BITS-1:0] head_pri_reg;
    logic [DATA_BITS-1:0]     head_data_reg;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    cell_cmd_t cmd;
    status_t   status_next;

    logic [PRIORITY_BITS-1:0] cell_pri       [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]     cell_data      [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_pri_next  [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]     cell_data_next [QUEUE_DEPTH];
    logic                     cell_keep      [QUEUE_DEPTH];

    // The response register frees itself when its content is taken, so a new
    // request can transfer in the same cycle.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == FULL_COUNT);
    assign is_empty  = (count_reg == '0);

    // Decode the operation into one command for the whole chain. A dropped
    // insert or an empty delete leaves every cell alone.
    always_comb
    begin
        cmd         = CELL_HOLD;
        status_next = ST_OK;
        count_next  = count_reg;
        if (accept)
        begin
            if (req.op == OP_INSERT)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd        = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd        = CELL_SHIFT;
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    // Cell chain. Cell 0 sees an always-keeping left neighbor, so a new
    // highest entry lands at the head; the last cell shifts in its own value
    // on delete (that slot falls out of the occupied range anyway).
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t               ctrl;
        logic                     left_keep;
        logic [PRIORITY_BITS-1:0] left_pri;
        logic [DATA_BITS-1:0]     left_data;
        logic [PRIORITY_BITS-1:0] right_pri;
        logic [DATA_BITS-1:0]     right_data;

        assign ctrl.cmd      = cmd;
        assign ctrl.occupied = (count_reg > COUNT_BITS'(i));

        if (i == 0)
        begin : g_first
            assign left_keep = 1'b1;
            assign left_pri  = req.priority_req;
            assign left_data = req.data_handle;
        end
        else
        begin : g_rest
            assign left_keep = cell_keep[i-1];
            assign left_pri  = cell_pri[i-1];
            assign left_data = cell_data[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_pri  = cell_pri[i];
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner
            assign right_pri  = cell_pri[i+1];
            assign right_data = cell_data[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .DATA_BITS     (DATA_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_pri    (req.priority_req),
            .new_data   (req.data_handle),
            .left_keep  (left_keep),
            .left_pri   (left_pri),
            .left_data  (left_data),
            .right_pri  (right_pri),
            .right_data (right_data),
            .keep       (cell_keep[i]),
            .pri        (cell_pri[i]),
            .data       (cell_data[i]),
            .pri_next   (cell_pri_next[i]),
            .data_next  (cell_data_next[i])
        );
    end

    // Control state: fill count and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload; head fields read zero on an empty queue, removed
    // fields are zero unless a delete took the head.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            head_valid_reg <= (count_next != '0);
            if (cmd == CELL_SHIFT)
            begin
                rem_pri_reg  <= cell_pri[0];
                rem_data_reg <= cell_data[0];
            end
            else
            begin
                rem_pri_reg  <= '0;
                rem_data_reg <= '0;
            end
            if (count_next != '0)
            begin
                head_pri_reg  <= cell_pri_next[0];
                head_data_reg <= cell_data_next[0];
            end
            else
            begin
                head_pri_reg  <= '0;
                head_data_reg <= '0;
            end
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.removed_priority = rem_pri_reg;
    assign rsp.removed_data     = rem_data_reg;
    assign rsp.head_valid       = head_valid_reg;
    assign rsp.head_priority    = head_pri_reg;
    assign rsp.head_data        = head_data_reg;
    assign rsp.entry_count      = count_reg;

    // The count reported always matches the held count, which never
    // passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count beyond queue depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_INSERT && is_full)
        |=> (status_reg == ST_FULL) && (count_reg == FULL_COUNT))
        else $error("insert into full queue not dropped");

    a_empty_delete: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_DELETE && is_empty)
        |=> (status_reg == ST_EMPTY) && (count_reg == '0) && (rem_pri_reg == '0))
        else $error("delete on empty queue misreported");

    a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (head_valid_reg == (count_reg != '0)))
        else $error("head flag disagrees with count");

endmodule

`default_nettype wire

@@ tb/sv/sorted_priority_queue_test.sv @@
// Self-checking testbench for sorted_priority_queue: ordered inserts, FIFO ties,
// full/empty status and head/count reporting, under random sender and receiver pacing.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.

module sorted_priority_queue_test;

    import spq_pkg::*;

    localparam int QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int PBITS       = DEF_PRIORITY_BITS;
    localparam int DBITS       = DEF_DATA_BITS;
    localparam int CBITS       = $clog2(QDEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASES      = 22;
    localparam int PHASE_ITEMS = 50;

    typedef logic [PBITS-1:0] prio_t;
    typedef logic [DBITS-1:0] handle_t;
    typedef logic [CBITS-1:0] count_t;

    // One response transfer as the queue should report it.
    typedef struct {
        status_t status;
        prio_t   removed_priority;
        handle_t removed_data;
        logic    head_valid;
        prio_t   head_priority;
        handle_t head_data;
        count_t  entry_count;
    } queue_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the queue contents, slot 0 is the head.
    // ------------------------------------------------------------------
    prio_t   shadow_prio   [QDEPTH];
    handle_t shadow_handle [QDEPTH];
    int      shadow_count = 0;

    queue_report_t awaited_reports[$];
    int            fail_count   = 0;
    int            report_index = 0;

    // Sender pacing: bursts of transfers separated by idle gaps.
    bit sender_gaps = 1'b0;
    int burst_left  = 0;

    // Receiver pacing: ready follows a rotating random pattern when enabled.
    bit          rsp_stalls    = 1'b0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_phase   = 0;

    // Insert lands behind every entry with priority >= its own (FIFO among ties);
    // delete pops the head. Full inserts and empty deletes leave state alone.
    function automatic queue_report_t apply_queue_op(logic op, prio_t pri, handle_t dat);
        queue_report_t r;
        int pos;
        r.status           = ST_OK;
        r.removed_priority = '0;
        r.removed_data     = '0;
        if (op == OP_INSERT) begin
            if (shadow_count >= QDEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= pri)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_prio[i]   = shadow_prio[i-1];
                    shadow_handle[i] = shadow_handle[i-1];
                end
                shadow_prio[pos]   = pri;
                shadow_handle[pos] = dat;
                shadow_count++;
            end
        end
        else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            r.removed_priority = shadow_prio[0];
            r.removed_data     = shadow_handle[0];
            for (int i = 0; i + 1 < shadow_count; i++) begin
                shadow_prio[i]   = shadow_prio[i+1];
                shadow_handle[i] = shadow_handle[i+1];
            end
            shadow_count--;
        end
        r.head_valid    = (shadow_count > 0);
        r.head_priority = (shadow_count > 0) ? shadow_prio[0] : '0;
        r.head_data     = (shadow_count > 0) ? shadow_handle[0] : '0;
        r.entry_count   = count_t'(shadow_count);
        return r;
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic [DBITS-1:0] want,
                                        logic [DBITS-1:0] got);
        if (got !== want)
            log_failure($sformatf("report %0d %s: expected 0x%0h, got 0x%0h",
                                  report_index, name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every response transfer is matched against the
    // oldest outstanding expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : report_check
        queue_report_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_reports.size() == 0) begin
                log_failure($sformatf("report %0d arrived with nothing outstanding",
                                      report_index));
            end
            else begin
                want = awaited_reports.pop_front();
                check_field("status",           want.status,           rsp_ch.status);
                check_field("removed_priority", want.removed_priority, rsp_ch.removed_priority);
                check_field("removed_data",     want.removed_data,     rsp_ch.removed_data);
                check_field("head_valid",       want.head_valid,       rsp_ch.head_valid);
                check_field("head_priority",    want.head_priority,    rsp_ch.head_priority);
                check_field("head_data",        want.head_data,        rsp_ch.head_data);
                check_field("entry_count",      want.entry_count,      rsp_ch.entry_count);
            end
            report_index++;
        end
    end

    // Receiver ready; the pattern always keeps bits 0 and 15 set so a stall
    // never runs from the end of one pattern into the next one.
    always @(negedge clk) begin
        if (!rsp_stalls) begin
            rsp_ch.ready <= 1'b1;
        end
        else begin
            rsp_ch.ready <= stall_pattern[stall_phase];
            if (stall_phase == 15) begin
                stall_phase   = 0;
                stall_pattern = ($urandom_range(0, 1) ? 16'($urandom())
                                                      : 16'($urandom() | $urandom()))
                                | 16'h8001;
            end
            else begin
                stall_phase++;
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drives one request, waits for its transfer, records the expected report,
    // then maybe idles. Valid stays high between back-to-back requests.
    task automatic send_request(input logic op, input prio_t pri, input handle_t dat);
        int gap;
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.priority_req <= pri;
        req_ch.data_handle  <= dat;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        awaited_reports.push_back(apply_queue_op(op, pri, dat));
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else begin
                burst_left--;
            end
        end
    endtask

    // Drops valid and holds off until every outstanding report has come back.
    task automatic wait_for_reports();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    // Delete on an empty queue straight out of reset.
    task automatic test_empty_delete();
        send_request(OP_DELETE, '1, '1);
        send_request(OP_DELETE, '0, '0);
    endtask

    // Fill to capacity with extreme and tied priorities, push into the full
    // queue, then pop a few so ties come out in arrival order.
    task automatic test_fill_and_overflow();
        prio_t   pri;
        handle_t dat;
        rsp_stalls = 1'b1;
        for (int i = 0; i < QDEPTH; i++) begin
            case (i % 4)
                0:       pri = '0;
                1:       pri = '1;
                2:       pri = prio_t'(1) << (PBITS - 1);
                default: pri = prio_t'($urandom());
            endcase
            dat = (i == 0) ? '0 : (i == 1) ? '1 : handle_t'($urandom());
            send_request(OP_INSERT, pri, dat);
        end
        // both dropped, even the top priority
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, '0, '0);
        repeat (4) send_request(OP_DELETE, prio_t'($urandom()), handle_t'($urandom()));
        wait_for_reports();
    endtask

    // Mixed traffic in phases: insert-heavy phases run into the full case,
    // delete-heavy ones into the empty case; narrow priority ranges give ties.
    task automatic test_random_traffic();
        int      insert_pct;
        int      prio_style;
        logic    op;
        prio_t   pri;
        handle_t dat;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 3)
                0:       insert_pct = $urandom_range(75, 95);
                1:       insert_pct = $urandom_range(40, 60);
                default: insert_pct = $urandom_range(5, 25);
            endcase
            prio_style  = $urandom_range(0, 2);
            sender_gaps = (phase % 4 != 0);
            rsp_stalls  = (phase % 5 != 1);
            burst_left  = $urandom_range(0, 16);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
                case (prio_style)
                    0: pri = prio_t'($urandom());
                    1: pri = prio_t'($urandom_range(0, 3));
                    default:
                        case ($urandom_range(0, 2))
                            0:       pri = '0;
                            1:       pri = '1;
                            default: pri = prio_t'($urandom());
                        endcase
                endcase
                dat = handle_t'($urandom());
                send_request(op, pri, dat);
            end
            if (phase % 6 == 5)
                wait_for_reports();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_INSERT;
        req_ch.priority_req = '0;
        req_ch.data_handle  = '0;
        rsp_ch.ready        = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_delete();
        test_fill_and_overflow();
        test_random_traffic();

        // drain, then give the registered response stage time to show any stray report
        wait_for_reports();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_test.sv
